### hdl/ps2mwd_pkg.sv
// shared types and constants for the ps2 mouse packet and wheel decoder
// no dependencies

package ps2mwd_pkg;

  localparam int BYTE_W  = 8;
  localparam int DELTA_W = 4;
  localparam int ACC_W   = 32;
  localparam int SYNC_BIT = 3;
  localparam int OUT_TDATA_W = 104;

  typedef enum logic [1:0] {
    SCROLL_NONE = 2'd0,
    SCROLL_DOWN = 2'd1,
    SCROLL_UP   = 2'd2
  } scroll_t;

  typedef struct packed {
    logic [ACC_W-1:0]          wheel_event_count;
    logic [ACC_W-1:0]          packet_count;
    logic signed [ACC_W-1:0]   wheel_total;
    logic signed [DELTA_W-1:0] wheel_delta;
    scroll_t                   scroll_action;
  } result_t;

endpackage

### hdl/ps2mwd_frame.sv
// packet framing state, wheel decode and running counters
// depends on ps2mwd_pkg

module ps2mwd_frame (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [ps2mwd_pkg::BYTE_W-1:0] rx_byte,
  input  logic                       wheel_en,
  output logic                       res_vld,
  output ps2mwd_pkg::result_t        res
);
  import ps2mwd_pkg::*;

  logic [1:0]              byte_index_r, byte_index_nxt;
  logic [BYTE_W-1:0]       first_byte_r, first_byte_nxt;
  logic [ACC_W-1:0]        position_r, position_nxt;
  logic [ACC_W-1:0]        packets_r, packets_nxt;
  logic [ACC_W-1:0]        events_r, events_nxt;

  logic              drop;
  logic [BYTE_W-1:0] fb;
  logic [2:0]        count;
  logic [2:0]        size;
  logic              wheel_act;
  logic [DELTA_W-1:0] delta;
  logic              nz;
  logic [ACC_W-1:0]  ext;

  always_comb begin
    drop      = (byte_index_r == 2'd0) && !rx_byte[SYNC_BIT];
    fb        = (byte_index_r == 2'd0) ? rx_byte : first_byte_r;
    count     = {1'b0, byte_index_r} + 3'd1;
    size      = wheel_en ? 3'd4 : 3'd3;
    res_vld   = !drop && (count >= size);
    wheel_act = res_vld && wheel_en && fb[SYNC_BIT];
    delta     = wheel_act ? rx_byte[DELTA_W-1:0] : '0;
    nz        = (delta != '0);
    ext       = {{(ACC_W-DELTA_W){delta[DELTA_W-1]}}, delta};

    byte_index_nxt = byte_index_r;
    first_byte_nxt = first_byte_r;
    position_nxt   = position_r;
    packets_nxt    = packets_r;
    events_nxt     = events_r;
    if (step && !drop) begin
      first_byte_nxt = fb;
      if (res_vld) begin
        byte_index_nxt = 2'd0;
        packets_nxt    = packets_r + 32'd1;
        if (nz) begin
          position_nxt = position_r + ext;
          events_nxt   = events_r + 32'd1;
        end
      end else begin
        byte_index_nxt = count[1:0];
      end
    end

    res.scroll_action     = nz ? (delta[DELTA_W-1] ? SCROLL_UP : SCROLL_DOWN) : SCROLL_NONE;
    res.wheel_delta       = delta;
    res.wheel_total       = nz ? (position_r + ext) : position_r;
    res.packet_count      = packets_r + 32'd1;
    res.wheel_event_count = nz ? (events_r + 32'd1) : events_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= 2'd0;
      first_byte_r <= '0;
      position_r   <= '0;
      packets_r    <= '0;
      events_r     <= '0;
    end else begin
      byte_index_r <= byte_index_nxt;
      first_byte_r <= first_byte_nxt;
      position_r   <= position_nxt;
      packets_r    <= packets_nxt;
      events_r     <= events_nxt;
    end
  end

  a_pkt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_vld |=> packets_r == $past(packets_r) + 32'd1)
    else $error("packet count did not advance");

  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step && !nz |=> $stable(position_r) && $stable(events_r))
    else $error("wheel state moved without wheel movement");

  a_no_wheel: assert property (@(posedge clk) disable iff (!rst_n)
    !wheel_en |-> res.scroll_action == SCROLL_NONE && res.wheel_delta == '0)
    else $error("scroll reported in three-byte mode");

  a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && drop |=> byte_index_r == 2'd0 && $stable(packets_r))
    else $error("unsynchronized byte changed framing");

endmodule

### hdl/ps2_mouse_packet_wheel_decoder_core.sv
// top level of the ps2 mouse packet and wheel decoder
// depends on ps2mwd_pkg and ps2mwd_frame

// Takes one received mouse byte per request and returns one result per completed
// packet (three bytes, or four with wheel mode set through cfg_we and cfg_wdata).
// A byte is accepted every cycle, except while a packet-ending byte waits behind a
// result held on out_tready. Each result passes the input register and then the
// result register before it is offered. Bytes that end no packet give no result.
// No clearing pass is needed after reset.

module ps2_mouse_packet_wheel_decoder_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,       // wheel_enabled
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,        // rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [ps2mwd_pkg::OUT_TDATA_W-1:0] out_tdata
                                        // scroll_action, wheel_delta, wheel_total,
                                        // packet_count, wheel_event_count, zero pad
);
  import ps2mwd_pkg::*;

  logic              wheel_en_r;
  logic              s1_vld_r, s1_vld_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_vld_r, out_vld_nxt;
  result_t           out_res_r;

  logic    adv;
  logic    res_vld;
  result_t res;

  ps2mwd_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .rx_byte  (s1_byte_r),
    .wheel_en (wheel_en_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  always_comb begin
    adv         = s1_vld_r && (!res_vld || !out_vld_r || out_tready);
    in_tready   = !s1_vld_r || adv;
    s1_vld_nxt  = in_tready ? in_tvalid : s1_vld_r;
    out_vld_nxt = (adv && res_vld) ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_en_r <= 1'b0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        wheel_en_r <= cfg_wdata;
      end
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
    if (adv && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_res_r};

endmodule
